### hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Round constants, initial chaining values, sequencer types and the SHA-256
// bit-mixing functions shared by the byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned NUM_CHAIN  = 8;
    localparam int unsigned NUM_SCHED  = 16;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    localparam logic [31:0] K_ROUND [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_CHAIN [NUM_CHAIN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic FUNC_FIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } t_phase;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

### hw/rtl/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream: buffers bytes into a 16-word schedule window,
// runs one compression round per cycle, pads on finish, emits the digest.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | to unit   | i_in_valid / o_in_stall | i_func, i_data_byte
//  out     | from unit | o_out_valid/ i_out_stall| o_digest_word, o_word_index,
//          |           |                         | o_last
//
//  Every 64th byte starts a compression in the shared round unit and a fold into
//  the chaining words. A finish word pushes one pad byte per cycle, held while
//  a block compresses (9 to 72 bytes, and a pause at offset 56 before the length
//  bytes), runs one or two compressions, then offers four digest words.
//  Synchronous active-low reset loads the initial chaining values; no sweep.
//  o_in_stall stays high from acceptance of a finish word until the last digest
//  word is taken, and while a block compresses; a stalled digest word holds.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    t_phase      r_phase;
    logic [31:0] r_chain [NUM_CHAIN];
    logic [31:0] r_s     [NUM_CHAIN];
    logic [31:0] r_w     [NUM_SCHED];
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [63:0] r_msg_bits;
    logic [63:0] r_len;
    logic [1:0]  r_oidx;
    logic        r_fin;

    logic        in_acc, out_acc;
    logic        push_en, wrap;
    logic [7:0]  push_data;
    logic [31:0] t1, t2, w_new;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign wrap    = push_en && (r_fill == 6'd63);

    // Round unit and schedule extension
    always_comb begin
        t1 = r_s[7] + big_sig1(r_s[4]) + ((r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]))
           + K_ROUND[r_rnd] + r_w[0];
        t2 = big_sig0(r_s[0])
           + ((r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]));
        w_new = r_w[0] + small_sig0(r_w[1]) + r_w[9] + small_sig1(r_w[14]);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_func == FUNC_FIN)) begin
                    n_state = ST_PAD;
                end else if (wrap) begin
                    n_state = ST_ROUND;
                end
            end
            ST_PAD: begin
                if (wrap) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_rnd == 6'd63) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                // a pending finish is marked by leaving the mark phase
                priority if (r_fin) begin
                    n_state = ST_OUT;
                end else if (r_phase != PH_MARK) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc && (r_oidx == 2'd3)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and byte push control
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        push_en     = 1'b0;
        push_data   = i_data_byte;
        unique case (r_state)
            ST_IDLE: begin
                push_en = in_acc && (i_func != FUNC_FIN);
            end
            ST_PAD: begin
                unique case (r_phase)
                    PH_MARK: begin
                        push_en   = 1'b1;
                        push_data = PAD_BYTE;
                    end
                    PH_ZERO: begin
                        push_en   = (r_fill != LEN_OFFSET);
                        push_data = 8'h00;
                    end
                    PH_LEN: begin
                        push_en   = 1'b1;
                        push_data = r_len[{~r_fill[2:0], 3'b000} +: 8];
                    end
                    default: begin
                        push_en   = 1'b0;
                        push_data = 8'h00;
                    end
                endcase
            end
            ST_ROUND, ST_FOLD, ST_OUT: begin
                push_en = 1'b0;
            end
            default: push_en = 1'b0;
        endcase
        o_word_index  = r_oidx;
        o_last        = (r_oidx == 2'd3);
        o_digest_word = {r_chain[{r_oidx, 1'b0}], r_chain[{r_oidx, 1'b1}]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_MARK;
            r_fin      <= 1'b0;
            r_fill     <= '0;
            r_rnd      <= '0;
            r_msg_bits <= '0;
            r_oidx     <= '0;
            for (int j = 0; j < NUM_CHAIN; j++) begin
                r_chain[j] <= IV_CHAIN[j];
            end
        end else begin
            r_state <= n_state;

            if (push_en) begin
                r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= push_data;
                r_fill <= r_fill + 6'd1;
            end

            if (in_acc && (i_func != FUNC_FIN)) begin
                r_msg_bits <= r_msg_bits + 64'd8;
            end

            if (in_acc && (i_func == FUNC_FIN)) begin
                r_len   <= r_msg_bits;
                r_phase <= PH_MARK;
            end

            // Advance the pad phase; the length phase marks the final block
            if (r_state == ST_PAD) begin
                if (r_phase == PH_MARK) begin
                    r_phase <= PH_ZERO;
                end else if (r_phase == PH_ZERO && r_fill == LEN_OFFSET) begin
                    r_phase <= PH_LEN;
                end
            end

            if (in_acc && (i_func == FUNC_FIN)) begin
                r_fin <= 1'b0;
            end else if (r_state == ST_PAD && r_phase == PH_LEN && wrap) begin
                r_fin <= 1'b1;
            end

            if (wrap) begin
                for (int j = 0; j < NUM_CHAIN; j++) begin
                    r_s[j] <= r_chain[j];
                end
            end

            if (r_state == ST_ROUND) begin
                r_s[0] <= t1 + t2;
                r_s[1] <= r_s[0];
                r_s[2] <= r_s[1];
                r_s[3] <= r_s[2];
                r_s[4] <= r_s[3] + t1;
                r_s[5] <= r_s[4];
                r_s[6] <= r_s[5];
                r_s[7] <= r_s[6];
                for (int j = 0; j < NUM_SCHED - 1; j++) begin
                    r_w[j] <= r_w[j + 1];
                end
                r_w[NUM_SCHED - 1] <= w_new;
                r_rnd <= r_rnd + 6'd1;
            end

            if (r_state == ST_FOLD) begin
                for (int j = 0; j < NUM_CHAIN; j++) begin
                    r_chain[j] <= r_chain[j] + r_s[j];
                end
            end

            if (out_acc) begin
                r_oidx <= r_oidx + 2'd1;
                if (r_oidx == 2'd3) begin
                    r_msg_bits <= '0;
                    r_fin      <= 1'b0;
                    r_phase    <= PH_MARK;
                    for (int j = 0; j < NUM_CHAIN; j++) begin
                        r_chain[j] <= IV_CHAIN[j];
                    end
                end
            end
        end
    end

    a_rnd_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd != 6'd63) |=> (r_rnd == $past(r_rnd) + 6'd1))
        else $error("round counter skipped");

    a_rnd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_ROUND) |-> (r_rnd == 6'd0))
        else $error("compression started mid-count");

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_in_stall && r_fill == 6'd0))
        else $error("digest offered with open block");

    a_len_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD && r_phase == PH_LEN) |-> (r_fill[5:3] == 3'b111))
        else $error("length bytes outside final eight");

    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> (r_state == ST_IDLE && r_msg_bits == 64'd0 && !r_fin))
        else $error("message state not reinitialized");

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the SHA-256 byte stream hasher. Message bytes and finish words go
// in through the input channel. A SHA-256 predictor in the bench works out
// the four digest words for each finish. Each word taken from the output
// channel is compared with them. Both channels idle and stall at random,
// except during one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last;
    } digest_beat_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_func      = OP_ABSORB;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last;

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [63:0] bit_count;

    digest_beat_t digest_q [$];
    int unsigned  mismatches = 0;
    int unsigned  words_sent = 0;
    bit           steady = 1'b0;

    sha256_byte_stream_hasher_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        logic [63:0] twice;
        twice = {v, v} >> n;
        return twice[31:0];
    endfunction

    function automatic void compress_blk();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    function automatic void push_blk_byte(input logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill = (blk_fill + 1) % 64;
        if (blk_fill == 0) begin
            compress_blk();
        end
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) begin
            chain_h[i] = START_CHAIN[i];
        end
        blk_fill  = 0;
        bit_count = 64'd0;
    endfunction

    // Fold one accepted word into the running hash; on finish queue the digest.
    function automatic void hash_accept(input logic fn, input logic [7:0] b);
        logic [63:0]  msg_len;
        digest_beat_t beat;
        if (fn == OP_ABSORB) begin
            bit_count += 64'd8;
            push_blk_byte(b);
            return;
        end
        msg_len = bit_count;
        push_blk_byte(8'h80);
        while (blk_fill != 56) begin
            push_blk_byte(8'h00);
        end
        for (int k = 0; k < 8; k++) begin
            push_blk_byte(msg_len[63 - 8*k -: 8]);
        end
        for (int k = 0; k < 4; k++) begin
            beat.digest_word = {chain_h[2*k], chain_h[2*k+1]};
            beat.word_index  = 2'(k);
            beat.last        = (k == 3);
            digest_q = {digest_q, beat};
        end
        restart_hash();
    endfunction

    task automatic send_word(input logic fn, input logic [7:0] b);
        while (!steady && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= fn;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        hash_accept(fn, b);
        words_sent++;
    endtask

    task automatic send_random_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_word(OP_ABSORB, 8'($urandom));
        end
        send_word(OP_FINISH, 8'($urandom));
    endtask

    // Favor lengths around the one-block and two-block padding limits.
    function automatic int unsigned pick_msg_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return $urandom_range(8, 0);
        if (r < 60) return $urandom_range(60, 52);
        if (r < 75) return $urandom_range(66, 62);
        if (r < 90) return $urandom_range(130, 117);
        return $urandom_range(200, 0);
    endfunction

    task automatic test_empty_message();
        send_word(OP_FINISH, 8'h00);
    endtask

    task automatic test_finish_ignores_data();
        send_word(OP_FINISH, 8'hff);
        send_word(OP_ABSORB, 8'h61);
        send_word(OP_ABSORB, 8'h62);
        send_word(OP_ABSORB, 8'h63);
        send_word(OP_FINISH, 8'ha5);
    endtask

    task automatic test_byte_extremes();
        send_word(OP_ABSORB, 8'h00);
        send_word(OP_ABSORB, 8'hff);
        send_word(OP_ABSORB, 8'h80);
        send_word(OP_ABSORB, 8'h7f);
        send_word(OP_ABSORB, 8'h01);
        send_word(OP_ABSORB, 8'hfe);
        send_word(OP_FINISH, 8'h5a);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        send_random_message(56);
        send_random_message($urandom_range(4, 0));
        steady = 1'b0;
    endtask

    // Trim the last message so the run stays near 170 words.
    task automatic test_random_messages();
        int unsigned len;
        while (words_sent < 165) begin
            len = pick_msg_len();
            if (words_sent + len + 1 > 175) begin
                len = 175 - words_sent - 1;
            end
            send_random_message(len);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 24);
    end

    always @(posedge i_clk) begin
        digest_beat_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (digest_q.size() == 0) begin
                $error("digest word with none expected: %h", o_digest_word);
                mismatches++;
            end else begin
                want = digest_q.pop_front();
                if (o_digest_word !== want.digest_word) begin
                    $error("digest_word expected %h actual %h", want.digest_word, o_digest_word);
                    mismatches++;
                end
                if (o_word_index !== want.word_index) begin
                    $error("word_index expected %0d actual %0d", want.word_index, o_word_index);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        restart_hash();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_message();
        test_finish_ignores_data();
        test_byte_extremes();
        test_back_to_back();
        test_random_messages();
        i_in_valid <= 1'b0;
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        // let any stray output show up
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
